@@ sv/limit_order_matcher_top_defines.svh @@
// Assertion helpers for the order matcher
`ifndef LIMIT_ORDER_MATCHER_TOP_DEFINES_SVH
`define LIMIT_ORDER_MATCHER_TOP_DEFINES_SVH

// implication checked on every edge outside reset
`define LOM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication checked outside reset
`define LOM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/lom_pkg.sv @@
package lom_pkg;

	localparam int ORDERS_PER_SIDE = 32;
	localparam int IDX_W = $clog2(ORDERS_PER_SIDE);
	localparam int CNT_W = $clog2(ORDERS_PER_SIDE + 1);
	localparam int PRICE_W = 32;
	localparam int QTY_W = 24;
	localparam int SEQ_W = 32;

	localparam logic [1:0] ST_TRADE = 2'd0;
	localparam logic [1:0] ST_DONE = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	// one order word as queued between front and engine
	typedef struct packed {
		logic               side;
		logic [PRICE_W-1:0] limit;
		logic [QTY_W-1:0]   qty;
		logic               zero;
	} order_t;

endpackage

@@ sv/limit_order_matcher_top.sv @@
// Price-time priority limit order matcher over a bounded book of 32 bids and 32 asks.
// Each accepted order yields its trade words, then one closing word with last set.
// A front queue of two orders takes input while the engine works. For every fill
// the engine scans the opposite side one entry a cycle, then makes the fill in
// S_DECIDE once the result register is free.
module limit_order_matcher_top
	import lom_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               side,
	input  logic [PRICE_W-1:0] limit_price,
	input  logic [QTY_W-1:0]   order_qty,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [QTY_W-1:0]   fill_qty,
	output logic [PRICE_W-1:0] fill_price,
	output logic [QTY_W-1:0]   rested_qty,
	output logic               last
);

`include "limit_order_matcher_top_defines.svh"

	logic   q_valid;
	logic   q_pop;
	order_t q_word;

	lom_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .side, .limit_price, .order_qty,
		.q_valid, .q_pop, .q_word
	);

	lom_engine u_engine (
		.clk, .arst_n, .q_valid, .q_pop, .q_word, .out_valid, .out_ready,
		.status, .fill_qty, .fill_price, .rested_qty, .last
	);

	`LOM_ASSERT_IMP(a_trade_nonzero, out_valid && !last, status == ST_TRADE && fill_qty != '0, "trade word with zero quantity")
	`LOM_ASSERT_IMP(a_close_status, out_valid && last, (status == ST_DONE || status == ST_FULL) && fill_qty == '0, "bad closing word")
	`LOM_ASSERT_NEXT(a_pop_starts, q_pop, !q_pop, "engine popped two orders back to back")

endmodule

@@ sv/lom_front.sv @@
module lom_front
	import lom_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               side,
	input  logic [PRICE_W-1:0] limit_price,
	input  logic [QTY_W-1:0]   order_qty,
	output logic               q_valid,
	input  logic               q_pop,
	output order_t             q_word
);

	order_t     fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign in_ready = (count_q != 2'd2);
	assign push = in_valid && in_ready;
	assign q_valid = (count_q != 2'd0);
	assign pop = q_pop && q_valid;
	assign q_word = fifo_q[rd_ptr_q];

	// classify and store the incoming word
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{side: side, limit: limit_price, qty: order_qty,
				zero: (order_qty == '0)};
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

@@ sv/lom_engine.sv @@
module lom_engine
	import lom_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_pop,
	input  order_t             q_word,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [QTY_W-1:0]   fill_qty,
	output logic [PRICE_W-1:0] fill_price,
	output logic [QTY_W-1:0]   rested_qty,
	output logic               last
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_DECIDE = 3'd2;
	localparam logic [2:0] S_CLOSE = 3'd3;

	// bid and ask books, one slot per resting order
	logic [PRICE_W-1:0] bid_price_q [ORDERS_PER_SIDE];
	logic [QTY_W-1:0]   bid_qty_q [ORDERS_PER_SIDE];
	logic [SEQ_W-1:0]   bid_seq_q [ORDERS_PER_SIDE];
	logic [PRICE_W-1:0] ask_price_q [ORDERS_PER_SIDE];
	logic [QTY_W-1:0]   ask_qty_q [ORDERS_PER_SIDE];
	logic [SEQ_W-1:0]   ask_seq_q [ORDERS_PER_SIDE];
	logic [SEQ_W-1:0]   counter_q;

	logic [2:0]         state_q;
	logic               sell_q;
	logic [PRICE_W-1:0] limit_q;
	logic [QTY_W-1:0]   remain_q;
	logic [CNT_W-1:0]   fills_q;
	logic [IDX_W-1:0]   idx_q;
	logic               found_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [PRICE_W-1:0] best_price_q;
	logic [QTY_W-1:0]   best_qty_q;
	logic [SEQ_W-1:0]   best_age_q;

	logic               out_valid_q;
	logic [1:0]         status_q;
	logic [QTY_W-1:0]   fill_qty_q;
	logic [PRICE_W-1:0] fill_price_q;
	logic [QTY_W-1:0]   rested_qty_q;
	logic               last_q;

	logic               slot_free;
	logic [PRICE_W-1:0] scan_price;
	logic [QTY_W-1:0]   scan_qty;
	logic [SEQ_W-1:0]   scan_age;
	logic               scan_better;
	logic               hit;
	logic [QTY_W-1:0]   take;
	logic [QTY_W-1:0]   remain_nx;
	logic               free_found;
	logic [IDX_W-1:0]   free_idx;

	assign slot_free = !out_valid_q || out_ready;
	assign q_pop = (state_q == S_IDLE) && q_valid;

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign fill_qty = fill_qty_q;
	assign fill_price = fill_price_q;
	assign rested_qty = rested_qty_q;
	assign last = last_q;

	// compare the scanned entry of the opposite side with the best so far
	always_comb begin
		scan_price = sell_q ? bid_price_q[idx_q] : ask_price_q[idx_q];
		scan_qty = sell_q ? bid_qty_q[idx_q] : ask_qty_q[idx_q];
		scan_age = counter_q - (sell_q ? bid_seq_q[idx_q] : ask_seq_q[idx_q]);
		if (!found_q) scan_better = 1'b1;
		else if (scan_price != best_price_q)
			scan_better = sell_q ? (scan_price > best_price_q) : (scan_price < best_price_q);
		else scan_better = (scan_age > best_age_q);
	end

	// fill decision against the chosen entry
	always_comb begin
		hit = found_q && (sell_q ? !(limit_q > best_price_q) : !(limit_q < best_price_q));
		take = (remain_q < best_qty_q) ? remain_q : best_qty_q;
		remain_nx = remain_q - take;
	end

	// lowest empty slot on the own side
	always_comb begin
		free_found = 1'b0;
		free_idx = '0;
		for (int i = ORDERS_PER_SIDE - 1; i >= 0; i--) begin
			if ((sell_q ? ask_qty_q[i] : bid_qty_q[i]) == '0) begin
				free_found = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	// book quantities: reset empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ORDERS_PER_SIDE; i++) begin
				bid_qty_q[i] <= '0;
				ask_qty_q[i] <= '0;
			end
		end else if (state_q == S_DECIDE && hit && slot_free) begin
			if (sell_q) bid_qty_q[best_idx_q] <= best_qty_q - take;
			else ask_qty_q[best_idx_q] <= best_qty_q - take;
		end else if (state_q == S_CLOSE && slot_free && remain_q != '0 && free_found) begin
			if (sell_q) ask_qty_q[free_idx] <= remain_q;
			else bid_qty_q[free_idx] <= remain_q;
		end
	end

	// price and sequence of a resting remainder
	always_ff @(posedge clk) begin
		if (state_q == S_CLOSE && slot_free && remain_q != '0 && free_found) begin
			if (sell_q) begin
				ask_price_q[free_idx] <= limit_q;
				ask_seq_q[free_idx] <= counter_q;
			end else begin
				bid_price_q[free_idx] <= limit_q;
				bid_seq_q[free_idx] <= counter_q;
			end
		end
	end

	// order datapath
	always_ff @(posedge clk) begin
		if (q_pop) begin
			sell_q <= q_word.side;
			limit_q <= q_word.limit;
			remain_q <= q_word.qty;
		end else if (state_q == S_DECIDE && hit && slot_free) begin
			remain_q <= remain_nx;
		end
		if (state_q == S_SCAN && scan_qty != '0 && scan_better) begin
			best_idx_q <= idx_q;
			best_price_q <= scan_price;
			best_qty_q <= scan_qty;
			best_age_q <= scan_age;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fills_q <= '0;
			idx_q <= '0;
			found_q <= 1'b0;
			counter_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						fills_q <= '0;
						idx_q <= '0;
						found_q <= 1'b0;
						state_q <= q_word.zero ? S_CLOSE : S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_qty != '0 && scan_better) found_q <= 1'b1;
					idx_q <= idx_q + 1'b1;
					if (idx_q == IDX_W'(ORDERS_PER_SIDE - 1)) state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (!hit) begin
						state_q <= S_CLOSE;
					end else if (slot_free) begin
						fills_q <= fills_q + 1'b1;
						idx_q <= '0;
						found_q <= 1'b0;
						if (remain_nx != '0 && fills_q != CNT_W'(ORDERS_PER_SIDE - 1))
							state_q <= S_SCAN;
						else state_q <= S_CLOSE;
					end
				end
				S_CLOSE: begin
					if (slot_free) begin
						if (remain_q != '0 && free_found) counter_q <= counter_q + 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DECIDE && hit && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (state_q == S_CLOSE && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DECIDE && hit && slot_free) begin
			status_q <= ST_TRADE;
			fill_qty_q <= take;
			fill_price_q <= best_price_q;
			rested_qty_q <= '0;
			last_q <= 1'b0;
		end else if (state_q == S_CLOSE && slot_free) begin
			status_q <= (remain_q != '0 && !free_found) ? ST_FULL : ST_DONE;
			fill_qty_q <= '0;
			fill_price_q <= '0;
			rested_qty_q <= free_found ? remain_q : '0;
			last_q <= 1'b1;
		end
	end

endmodule

@@ verif/limit_order_matcher_top_test.sv @@
module limit_order_matcher_top_test;
	import lom_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               side;
	logic [PRICE_W-1:0] limit_price;
	logic [QTY_W-1:0]   order_qty;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         status;
	logic [QTY_W-1:0]   fill_qty;
	logic [PRICE_W-1:0] fill_price;
	logic [QTY_W-1:0]   rested_qty;
	logic               last;

	limit_order_matcher_top DUT (.*);

	localparam int N_RANDOM = 222;
	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 200;

	typedef struct packed {
		logic               sd;
		logic [PRICE_W-1:0] px;
		logic [QTY_W-1:0]   qty;
	} order_word_t;

	typedef struct packed {
		logic [1:0]         st;
		logic [QTY_W-1:0]   fq;
		logic [PRICE_W-1:0] fp;
		logic [QTY_W-1:0]   rq;
		logic               lst;
	} fill_word_t;

	// directed rows; chk set where the closing word is typed in
	typedef struct {
		order_word_t o;
		bit          chk;
		fill_word_t  r;
	} row_t;

	// book copy
	logic [PRICE_W-1:0] book_px  [2][ORDERS_PER_SIDE];
	logic [QTY_W-1:0]   book_qty [2][ORDERS_PER_SIDE];
	logic [SEQ_W-1:0]   book_seq [2][ORDERS_PER_SIDE];
	logic [SEQ_W-1:0]   arrivals;

	fill_word_t  expected_fills[$];
	row_t        orders_sent[$];
	row_t        typed_close[$];
	int          n_errors = 0;
	int          n_accepted = 0;
	int          n_fills = 0;
	int          n_trades = 0;
	int          n_dropped = 0;
	int          idle_cycles = 0;
	bit          hold_off = 0;
	row_t        rows[$];

	function automatic int best_resting(int s, bit want_low);
		int b;
		b = -1;
		for (int i = 0; i < ORDERS_PER_SIDE; i++) begin
			if (book_qty[s][i] == 0)
				continue;
			if (b < 0)
				b = i;
			else if (book_px[s][i] != book_px[s][b]) begin
				if (want_low ? (book_px[s][i] < book_px[s][b]) : (book_px[s][i] > book_px[s][b]))
					b = i;
			end else if (SEQ_W'(arrivals - book_seq[s][i]) > SEQ_W'(arrivals - book_seq[s][b]))
				b = i;
		end
		return b;
	endfunction

	// match one order against the book and queue its words
	function automatic void match_order(order_word_t o);
		int opp, own, b, n, slot;
		logic [QTY_W-1:0] remain, t;
		logic [PRICE_W-1:0] p;
		fill_word_t w;
		opp = o.sd ? 0 : 1;
		own = o.sd ? 1 : 0;
		remain = o.qty;
		n = 0;
		slot = -1;
		while (remain != 0 && n < ORDERS_PER_SIDE) begin
			b = best_resting(opp, !o.sd);
			if (b < 0)
				break;
			p = book_px[opp][b];
			if (o.sd ? (o.px > p) : (o.px < p))
				break;
			t = (remain < book_qty[opp][b]) ? remain : book_qty[opp][b];
			remain -= t;
			book_qty[opp][b] -= t;
			w = '{st: ST_TRADE, fq: t, fp: p, rq: '0, lst: 1'b0};
			expected_fills.push_back(w);
			n++;
		end
		w = '{st: ST_DONE, fq: '0, fp: '0, rq: '0, lst: 1'b1};
		if (remain != 0) begin
			for (int i = 0; i < ORDERS_PER_SIDE; i++)
				if (slot < 0 && book_qty[own][i] == 0)
					slot = i;
			if (slot < 0)
				w.st = ST_FULL;
			else begin
				book_px[own][slot] = o.px;
				book_qty[own][slot] = remain;
				book_seq[own][slot] = arrivals;
				arrivals++;
				w.rq = remain;
			end
		end
		expected_fills.push_back(w);
	endfunction

	function automatic order_word_t rand_order(logic [PRICE_W-1:0] mid);
		order_word_t o;
		o.sd = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 9))
			0: o.px = $urandom();
			1: o.px = $urandom_range(0, 1) ? '1 : '0;
			default: o.px = mid - 6 + $urandom_range(0, 12);
		endcase
		case ($urandom_range(0, 9))
			0: o.qty = QTY_W'($urandom());
			1: o.qty = '0;
			2: o.qty = '1;
			default: o.qty = QTY_W'($urandom_range(1, 40));
		endcase
		return o;
	endfunction

	// an order with no typed-in result
	function automatic row_t plain_row(order_word_t o);
		row_t r;
		r.o = o;
		r.chk = 0;
		r.r = '0;
		return r;
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
	end

	// model update on each accepted word, typed result lined up with it
	always @(posedge clk) begin
		row_t r;
		if (arst_n && in_valid && in_ready) begin
			match_order('{sd: side, px: limit_price, qty: order_qty});
			n_accepted++;
			if (orders_sent.size() != 0) begin
				r = orders_sent[0];
				orders_sent.delete(0);
			end else begin
				r = plain_row('{sd: side, px: limit_price, qty: order_qty});
			end
			typed_close.push_back(r);
		end
	end

	// compare each result word against the oldest expectation
	always @(posedge clk) begin
		fill_word_t e;
		row_t       t;
		if (arst_n && out_valid && out_ready) begin
			n_fills++;
			if (expected_fills.size() == 0) begin
				$error("unexpected result word: status %0d", status);
				n_errors++;
			end else begin
				e = expected_fills[0];
				expected_fills.delete(0);
				if (status === ST_TRADE)
					n_trades++;
				if (status === ST_FULL)
					n_dropped++;
				if (status !== e.st) begin
					$error("status: expected %0d, got %0d", e.st, status); n_errors++;
				end
				if (fill_qty !== e.fq) begin
					$error("fill_qty: expected %0d, got %0d", e.fq, fill_qty); n_errors++;
				end
				if (fill_price !== e.fp) begin
					$error("fill_price: expected %0d, got %0d", e.fp, fill_price);
					n_errors++;
				end
				if (rested_qty !== e.rq) begin
					$error("rested_qty: expected %0d, got %0d", e.rq, rested_qty);
					n_errors++;
				end
				if (last !== e.lst) begin
					$error("last: expected %0d, got %0d", e.lst, last); n_errors++;
				end
				// typed-in closing word for directed rows
				if (e.lst && typed_close.size() != 0) begin
					t = typed_close[0];
					typed_close.delete(0);
					if (t.chk) begin
						if (status !== t.r.st) begin
							$error("status: expected %0d, got %0d", t.r.st, status);
							n_errors++;
						end
						if (fill_qty !== t.r.fq) begin
							$error("fill_qty: expected %0d, got %0d", t.r.fq, fill_qty);
							n_errors++;
						end
						if (fill_price !== t.r.fp) begin
							$error("fill_price: expected %0d, got %0d", t.r.fp, fill_price);
							n_errors++;
						end
						if (rested_qty !== t.r.rq) begin
							$error("rested_qty: expected %0d, got %0d", t.r.rq, rested_qty);
							n_errors++;
						end
						if (last !== t.r.lst) begin
							$error("last: expected %0d, got %0d", t.r.lst, last);
							n_errors++;
						end
					end
				end
			end
		end
	end

	// receiver stalls: random, with one long hold-off
	initial begin
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off)
				out_ready <= 0;
			else
				case ($urandom_range(0, 7))
					0, 1: out_ready <= 0;
					default: out_ready <= 1;
				endcase
		end
	end

	initial begin
		wait (n_accepted >= 60);
		@(posedge clk);
		hold_off = 1;
		repeat (600) @(posedge clk);
		hold_off = 0;
	end

	// watchdog on cycles with no acceptance
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("** limit_order_matcher_top: FAILED **");
			$finish;
		end
	end

	task automatic send_order(order_word_t o);
		in_valid <= 1;
		side <= o.sd;
		limit_price <= o.px;
		order_qty <= o.qty;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic send_row(row_t r);
		orders_sent.push_back(r);
		send_order(r.o);
	endtask

	function automatic void add_row(logic sd, logic [PRICE_W-1:0] px, logic [QTY_W-1:0] q,
		bit c, logic [1:0] st, logic [QTY_W-1:0] rq);
		row_t r;
		r.o = '{sd: sd, px: px, qty: q};
		r.chk = c;
		r.r = '{st: st, fq: '0, fp: '0, rq: rq, lst: 1'b1};
		rows.push_back(r);
	endfunction

	// stimulus
	initial begin
		int burst;
		int gap;
		logic [PRICE_W-1:0] mid;
		row_t rw;
		in_valid = 0;
		side = 0;
		limit_price = '0;
		order_qty = '0;
		for (int s = 0; s < 2; s++)
			for (int i = 0; i < ORDERS_PER_SIDE; i++) begin
				book_px[s][i] = '0;
				book_qty[s][i] = '0;
				book_seq[s][i] = '0;
			end
		arrivals = '0;

		// directed: zero qty, extremes, crossing, time priority, partial sweep
		add_row(0, 32'd100, '0, 1, ST_DONE, '0);
		add_row(1, 32'hFFFF_FFFF, 24'd5, 1, ST_DONE, 24'd5);
		add_row(0, 32'd0, 24'hFF_FFFF, 1, ST_DONE, 24'hFF_FFFF);
		add_row(1, 32'hFFFF_FFFF, 24'd3, 1, ST_DONE, 24'd3);
		add_row(0, 32'hFFFF_FFFF, 24'd20, 0, ST_DONE, '0);
		add_row(1, 32'd0, 24'd1, 0, ST_DONE, '0);
		add_row(1, 32'd50, 24'd7, 0, ST_DONE, '0);
		add_row(1, 32'd50, 24'd4, 0, ST_DONE, '0);
		add_row(1, 32'd40, 24'd2, 0, ST_DONE, '0);
		add_row(0, 32'd50, 24'd10, 0, ST_DONE, '0);
		add_row(0, 32'd39, 24'd1, 0, ST_DONE, '0);
		add_row(1, 32'd0, 24'hFF_FFFF, 0, ST_DONE, '0);
		add_row(0, 32'd0, '0, 1, ST_DONE, '0);

		@(posedge arst_n);
		@(posedge clk);
		foreach (rows[k]) begin
			send_row(rows[k]);
			in_valid <= 0;
			@(posedge clk);
		end

		// fill the bid side to overflow: one bid rests already, 34 small bids follow,
		// the last three find the side full
		for (int k = 0; k < ORDERS_PER_SIDE + 2; k++) begin
			rw = plain_row('{sd: 1'b0, px: PRICE_W'(k + 1), qty: 24'd1});
			if (k >= ORDERS_PER_SIDE - 1) begin
				rw.chk = 1;
				rw.r = '{st: ST_FULL, fq: '0, fp: '0, rq: '0, lst: 1'b1};
			end
			send_row(rw);
		end
		send_row(plain_row('{sd: 1'b1, px: 32'd0, qty: 24'hFF_FFFF}));

		// random: bursts around a mid price that now and then jumps
		mid = 32'd1000;
		for (int k = 0; k < N_RANDOM; ) begin
			burst = $urandom_range(1, 12);
			for (int j = 0; j < burst && k < N_RANDOM; j++, k++) begin
				if ($urandom_range(0, 19) == 0)
					mid = $urandom_range(0, 1) ? 32'd8 : 32'hFFFF_FFF0;
				else if ($urandom_range(0, 9) == 0)
					mid = 32'd1000;
				send_row(plain_row(rand_order(mid)));
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
			if (gap != 0) begin
				in_valid <= 0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 0;

		while (expected_fills.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Run: %0d orders, %0d result words, %0d trades, %0d dropped remainders",
			n_accepted, n_fills, n_trades, n_dropped);
		if (n_errors == 0)
			$display("** limit_order_matcher_top: PASSED **");
		else
			$display("** limit_order_matcher_top: FAILED **");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+sv
sv/lom_pkg.sv
sv/lom_front.sv
sv/lom_engine.sv
sv/limit_order_matcher_top.sv
verif/limit_order_matcher_top_test.sv
